@@ sv/brf_pkg.sv @@
// shared types and constants for the byte ring fifo with deferred commit
// no dependencies; imported by byte_ring_fifo_deferred_commit
package brf_pkg;

   localparam int CmdW  = 3;
   localparam int ByteW = 8;
   localparam int LenW  = 7;

   // command codes carried in req_cmd
   typedef enum logic [CmdW-1:0] {
      CMD_WRITE      = 3'd0,
      CMD_WRITE_ONLY = 3'd1,
      CMD_COMMIT     = 3'd2,
      CMD_READ       = 3'd3,
      CMD_READ_ONLY  = 3'd4,
      CMD_RELEASE    = 3'd5
   } cmd_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

@@ sv/byte_ring_fifo_deferred_commit.sv @@
// top level of the byte ring fifo with deferred commit and release
// depends on brf_pkg for command codes, state type and field widths

// Ring of up to DEPTH bytes held in one synchronous memory with a
// registered read port. Every command other than a read gives one
// response beat. A read of n bytes (n at least one and no more than the
// occupancy) gives n beats, one memory read a cycle while the response
// slot is free; the read port's output register is the response data
// register, so a beat is produced in every cycle that rsp_ready is high
// and the next command is taken once the last memory read has been
// issued. The store has no reset and no clearing pass; capacity writes
// clear only the indices and the occupancy and take effect at once.
module byte_ring_fifo_deferred_commit
   import brf_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LenW-1:0]  csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CmdW-1:0]  req_cmd,
   input  logic [ByteW-1:0] req_data_in,
   input  logic [LenW-1:0]  req_length,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_status,
   output logic [ByteW-1:0] rsp_data_out,
   output logic             rsp_data_valid,
   output logic             rsp_last
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = (PW + 1 > LenW) ? PW + 1 : LenW;
   localparam logic [LenW-1:0] CapReset = (DEPTH < 64) ? LenW'(DEPTH) : LenW'(64);

   // ring storage and its registered read port
   logic [ByteW-1:0] mem [DEPTH];
   logic [ByteW-1:0] rdata_ff;

   state_type        state_ff, state_in;
   logic [LenW-1:0]  cap_ff, cap_in;
   logic [PW-1:0]    wpos_ff, wpos_in;
   logic [PW-1:0]    rpos_ff, rpos_in;
   logic [LenW-1:0]  occ_ff, occ_in;
   logic [LenW-1:0]  remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             status_ff, status_in;
   logic             dvalid_ff, dvalid_in;
   logic             last_ff, last_in;

   logic             mem_we;
   logic             rd_en;
   logic             slot_free;
   logic             accept;
   logic [PW-1:0]    wpos_next;
   logic [PW-1:0]    rpos_next;
   logic [LenW:0]    commit_sum;

   // next ring index, wrapping at the capacity
   function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos,
                                              input logic [LenW-1:0] cap);
      logic [NW-1:0] nxt;
      nxt = NW'(pos) + NW'(1);
      if (nxt >= NW'(cap)) begin
         return '0;
      end
      return nxt[PW-1:0];
   endfunction

   // capacity limited to one through DEPTH
   function automatic logic [LenW-1:0] limit_cap(input logic [LenW-1:0] v);
      if (v == '0) begin
         return LenW'(1);
      end
      if (32'(v) > DEPTH) begin
         return LenW'(DEPTH);
      end
      return v;
   endfunction

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign wpos_next  = advance(wpos_ff, cap_ff);
   assign rpos_next  = advance(rpos_ff, cap_ff);
   assign commit_sum = {1'b0, occ_ff} + {1'b0, req_length};

   // response ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_valid = dvalid_ff;
   assign rsp_last       = last_ff;
   assign rsp_data_out   = dvalid_ff ? rdata_ff : '0;

   // command decode and read sequencer
   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      wpos_in      = wpos_ff;
      rpos_in      = rpos_ff;
      occ_in       = occ_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      dvalid_in    = dvalid_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               dvalid_in    = 1'b0;
               last_in      = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_WRITE, CMD_WRITE_ONLY: begin
                     if (occ_ff >= cap_ff) begin
                        status_in = 1'b1;
                     end else begin
                        mem_we  = 1'b1;
                        wpos_in = wpos_next;
                        if (cmd_type'(req_cmd) == CMD_WRITE) begin
                           occ_in = occ_ff + LenW'(1);
                        end
                     end
                  end
                  CMD_COMMIT: begin
                     occ_in = (commit_sum > {1'b0, cap_ff}) ? cap_ff : commit_sum[LenW-1:0];
                  end
                  CMD_RELEASE: begin
                     occ_in = (occ_ff > req_length) ? occ_ff - req_length : '0;
                  end
                  CMD_READ, CMD_READ_ONLY: begin
                     if (req_length > occ_ff) begin
                        status_in = 1'b1;
                     end else if (req_length != '0) begin
                        // first byte read right away
                        rd_en     = 1'b1;
                        rpos_in   = rpos_next;
                        dvalid_in = 1'b1;
                        last_in   = (req_length == LenW'(1));
                        remain_in = req_length - LenW'(1);
                        if (req_length != LenW'(1)) begin
                           state_in = ST_READ;
                        end
                        if (cmd_type'(req_cmd) == CMD_READ) begin
                           occ_in = occ_ff - req_length;
                        end
                     end
                  end
                  default: begin
                     status_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            // one byte a beat while the response slot drains
            if (slot_free) begin
               rd_en        = 1'b1;
               rpos_in      = rpos_next;
               rsp_valid_in = 1'b1;
               status_in    = 1'b0;
               dvalid_in    = 1'b1;
               last_in      = (remain_ff == LenW'(1));
               remain_in    = remain_ff - LenW'(1);
               if (remain_ff == LenW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write clears indices and occupancy
      if (csr_we) begin
         cap_in  = limit_cap(csr_wdata);
         wpos_in = '0;
         rpos_in = '0;
         occ_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CapReset;
         wpos_ff      <= '0;
         rpos_ff      <= '0;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wpos_ff      <= wpos_in;
         rpos_ff      <= rpos_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response flags
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dvalid_ff <= dvalid_in;
      last_ff   <= last_in;
   end

   // ring memory write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wpos_ff] <= req_data_in;
      end
   end

   // ring memory read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rpos_ff];
      end
   end

endmodule
